[rtl/sre_pkg.sv]
// Shared definitions for the signed radix digit emitter.
// Holds the sizing constants, register index codes, status structs and symbol lookup.
// Depends on nothing.
package sre_pkg;

  localparam int MAX_BASE    = 32;
  localparam int NUM_W       = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = $clog2(MAX_BASE);
  localparam int RADIX_W     = 6;
  localparam int MAX_DIGITS  = NUM_W;
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int ALPHA_REGS  = 4;
  localparam int ALPHA_REG_W = 64;
  localparam int ALPHA_W     = ALPHA_REGS * ALPHA_REG_W;
  localparam int CFG_INDEX_W = 3;
  localparam int BIT_CNT_W   = $clog2(NUM_W);

  localparam logic [CFG_INDEX_W-1:0] CFG_SYM_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_0   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_1   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_2   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_3   = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef logic [ALPHA_W-1:0] alpha_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  typedef struct packed {
    logic               digit_valid;
    logic               finished;
    logic [DIGIT_W-1:0] digit;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] sym_at(input alpha_t alpha,
                                               input logic [DIGIT_W-1:0] idx);
    logic [DIGIT_W+2:0] base;
    base = {idx, 3'b000};
    return alpha[base +: CHAR_W];
  endfunction

endpackage

[rtl/sre_alpha_check.sv]
// Serial alphabet checker: one symbol per cycle against the range rules and the earlier symbols.
// Depends on sre_pkg.
module sre_alpha_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sre_pkg::RADIX_W-1:0]  sym_count,
  input  sre_pkg::alpha_t              alpha,
  output sre_pkg::chk_status_t         status
);

  logic                         running;
  logic                         done;
  logic                         fail;
  logic [sre_pkg::DIGIT_W-1:0]  idx;
  logic [sre_pkg::CHAR_W-1:0]   sym;
  logic                         dup;
  logic                         bad;
  logic                         idx_last;
  logic                         len_bad;

  assign sym      = sre_pkg::sym_at(alpha, idx);
  assign bad      = (sym == sre_pkg::CHAR_PLUS) || (sym == sre_pkg::CHAR_MINUS) ||
                    (sym < sre_pkg::CHAR_SPACE) || sym[7] || dup;
  assign idx_last = ({1'b0, idx} == sym_count - 6'd1);
  assign len_bad  = (sym_count < 6'd2) || (sym_count > 6'(sre_pkg::MAX_BASE));

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < sre_pkg::MAX_BASE; j++) begin
      if ((j < int'(idx)) && (sre_pkg::sym_at(alpha, j[sre_pkg::DIGIT_W-1:0]) == sym)) begin
        dup = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      fail    <= 1'b0;
      idx     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        fail    <= len_bad;
        idx     <= '0;
      end else if (running) begin
        if (fail) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          fail <= bad;
          idx  <= idx + 1'b1;
          if (idx_last) begin
            running <= 1'b0;
            done    <= 1'b1;
          end
        end
      end
    end
  end

  assign status.done = done;
  assign status.ok   = !fail;

endmodule

[rtl/sre_radix_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, one digit per word pass.
// The quotient replaces the dividend in place until it reaches zero. Depends on sre_pkg.
module sre_radix_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sre_pkg::NUM_W-1:0]    dividend,
  input  logic [sre_pkg::RADIX_W-1:0]  radix,
  output sre_pkg::div_status_t         status
);

  logic                           busy;
  logic [sre_pkg::NUM_W-1:0]      quo;
  logic [sre_pkg::NUM_W-1:0]      quo_next;
  logic [sre_pkg::DIGIT_W-1:0]    rem;
  logic [sre_pkg::DIGIT_W-1:0]    rem_next;
  logic [sre_pkg::DIGIT_W:0]      trial;
  logic [sre_pkg::DIGIT_W:0]      diff;
  logic                           ge;
  logic [sre_pkg::BIT_CNT_W-1:0]  bit_cnt;
  logic                           pass_end;

  assign trial    = {rem, quo[sre_pkg::NUM_W-1]};
  assign ge       = (trial >= radix);
  assign diff     = trial - radix;
  assign rem_next = ge ? diff[sre_pkg::DIGIT_W-1:0] : trial[sre_pkg::DIGIT_W-1:0];
  assign quo_next = {quo[sre_pkg::NUM_W-2:0], ge};
  assign pass_end = busy && (bit_cnt == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + 1'b1;
      if (pass_end && (quo_next == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= pass_end ? '0 : rem_next;
    end
  end

  assign status.digit_valid = pass_end;
  assign status.finished    = pass_end && (quo_next == '0);
  assign status.digit       = rem_next;

endmodule

[rtl/sre_digit_stack.sv]
// Last-in first-out shift register holding the digits of one number.
// Digits enter and leave at the low end. Depends on sre_pkg.
module sre_digit_stack (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         pop,
  input  logic [sre_pkg::DIGIT_W-1:0]  digit,
  output logic [sre_pkg::DIGIT_W-1:0]  top,
  output logic [sre_pkg::COUNT_W-1:0]  count
);

  logic [sre_pkg::MAX_DIGITS-1:0][sre_pkg::DIGIT_W-1:0] stack;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count + 1'b1;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack <= {stack[sre_pkg::MAX_DIGITS-2:0], digit};
    end else if (pop) begin
      stack <= {digit, stack[sre_pkg::MAX_DIGITS-1:1]};
    end
  end

  assign top = stack[0];

endmodule

[rtl/signed_radix_digit_emitter.sv]
// Top level of the signed radix digit emitter: configuration registers, sequencer and
// output register. Depends on sre_pkg, sre_alpha_check, sre_radix_div and sre_digit_stack.
//
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the symbol
// count at index 0 and the four alphabet words at indices 1 to 4; other indices are ignored.
// It is always ready. It must be written only while no number is in progress; the block
// does not enforce this. A request on the number channel is taken only when the previous
// number has been fully converted. The alphabet is checked first at one symbol per cycle.
// An invalid alphabet ends the request with no characters. Digits are produced least
// significant first by a bit-serial divider and are held in a digit stack. A negative
// number loads '-' into the character register as division starts. The digits then leave
// most significant first, one character per cycle while char_ready is high, with last set
// on the final one.
// The character register holds its request while char_ready is low; the sign and the digit
// emission stall until it is taken. Reset clears the configuration registers and drops all
// valid signals.
module signed_radix_digit_emitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sre_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sre_pkg::ALPHA_REG_W-1:0]  cfg_data,
  input  logic                             number_valid,
  output logic                             number_ready,
  input  logic signed [sre_pkg::NUM_W-1:0] number,
  output logic                             char_valid,
  input  logic                             char_ready,
  output logic [sre_pkg::CHAR_W-1:0]       character,
  output logic                             last
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_SIGN   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                             state;
  state_t                             state_next;
  logic [sre_pkg::RADIX_W-1:0]        sym_count;
  sre_pkg::alpha_t                    alpha;
  logic [sre_pkg::NUM_W-1:0]          raw;
  logic [sre_pkg::NUM_W-1:0]          magnitude;
  logic                               accept;
  logic                               chk_start;
  logic                               div_start;
  logic                               out_free;
  logic                               load;
  logic [sre_pkg::CHAR_W-1:0]         load_char;
  logic                               load_last;
  logic                               pop;
  logic [sre_pkg::DIGIT_W-1:0]        stk_top;
  logic [sre_pkg::COUNT_W-1:0]        stk_count;
  sre_pkg::chk_status_t               chk;
  sre_pkg::div_status_t               div;

  assign cfg_ready    = 1'b1;
  assign number_ready = (state == ST_IDLE);
  assign accept       = number_valid && number_ready;
  assign out_free     = !char_valid || char_ready;
  assign magnitude    = raw[sre_pkg::NUM_W-1] ? (~raw + 1'b1) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_count <= '0;
      alpha     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sre_pkg::CFG_SYM_COUNT: sym_count <= cfg_data[sre_pkg::RADIX_W-1:0];
        sre_pkg::CFG_ALPHA_0:  alpha[0*sre_pkg::ALPHA_REG_W +: sre_pkg::ALPHA_REG_W] <= cfg_data;
        sre_pkg::CFG_ALPHA_1:  alpha[1*sre_pkg::ALPHA_REG_W +: sre_pkg::ALPHA_REG_W] <= cfg_data;
        sre_pkg::CFG_ALPHA_2:  alpha[2*sre_pkg::ALPHA_REG_W +: sre_pkg::ALPHA_REG_W] <= cfg_data;
        sre_pkg::CFG_ALPHA_3:  alpha[3*sre_pkg::ALPHA_REG_W +: sre_pkg::ALPHA_REG_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    chk_start  = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    load_char  = sre_pkg::sym_at(alpha, stk_top);
    load_last  = (stk_count == sre_pkg::COUNT_W'(1));
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          chk_start  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk.done) begin
          if (!chk.ok) begin
            state_next = ST_IDLE;
          end else if (raw[sre_pkg::NUM_W-1]) begin
            state_next = ST_SIGN;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_SIGN: begin
        load_char = sre_pkg::CHAR_MINUS;
        load_last = 1'b0;
        if (out_free) begin
          load       = 1'b1;
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div.finished) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          pop  = 1'b1;
          if (load_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw <= number;
    end
    if (load) begin
      character <= load_char;
      last      <= load_last;
    end
  end

  sre_alpha_check u_check (
    .clk       (clk),
    .rst       (rst),
    .start     (chk_start),
    .sym_count (sym_count),
    .alpha     (alpha),
    .status    (chk)
  );

  sre_radix_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (magnitude),
    .radix    (sym_count),
    .status   (div)
  );

  sre_digit_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .push  (div.digit_valid),
    .pop   (pop),
    .digit (div.digit),
    .top   (stk_top),
    .count (stk_count)
  );

  // The stack never holds more digits than a 32-bit magnitude can have.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stk_count <= sre_pkg::COUNT_W'(sre_pkg::MAX_DIGITS))
    else $error("digit stack overflow");

  // Digits are only produced while the sequencer waits for division.
  a_push_in_divide: assert property (@(posedge clk) disable iff (rst)
    div.digit_valid |-> (state == ST_DIVIDE))
    else $error("digit produced outside division");

  // Emission never starts on an empty stack.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (stk_count != '0))
    else $error("emission with empty digit stack");

  // The final digit of a number is presented with last set.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && load && stk_count == sre_pkg::COUNT_W'(1)) |=> (char_valid && last))
    else $error("final character without last");

endmodule

[tb/sre_char_checker.sv]
`timescale 1ns / 100ps
// Checker for the signed radix digit emitter: follows the configuration, number and character
// requests, predicts the characters of every accepted number and compares them in order.
// Depends on sre_pkg.
module sre_char_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sre_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sre_pkg::ALPHA_REG_W-1:0]  cfg_data,
  input  logic                             number_valid,
  input  logic                             number_ready,
  input  logic signed [sre_pkg::NUM_W-1:0] number,
  input  logic                             char_valid,
  input  logic                             char_ready,
  input  logic [sre_pkg::CHAR_W-1:0]       character,
  input  logic                             last,
  output int                               mismatches,
  output int                               chars_pending,
  output int                               chars_checked
);

  typedef struct packed {
    logic [sre_pkg::CHAR_W-1:0] glyph;
    logic                       final_char;
  } char_item_t;

  char_item_t                        pending_chars [$];
  char_item_t                        head;
  logic [sre_pkg::RADIX_W-1:0]       radix_setting;
  logic [sre_pkg::ALPHA_REG_W-1:0]   alpha_words [sre_pkg::ALPHA_REGS];

  function automatic logic [sre_pkg::CHAR_W-1:0] symbol_of(input int idx);
    return alpha_words[idx >> 3][(idx & 7) * 8 +: sre_pkg::CHAR_W];
  endfunction

  function automatic bit alphabet_usable();
    int                         n;
    logic [sre_pkg::CHAR_W-1:0] c;
    n = int'(radix_setting);
    if (n < 2 || n > sre_pkg::MAX_BASE) return 1'b0;
    for (int i = 0; i < n; i++) begin
      c = symbol_of(i);
      if (c == sre_pkg::CHAR_PLUS || c == sre_pkg::CHAR_MINUS || c < sre_pkg::CHAR_SPACE ||
          c >= 8'h80) return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        if (symbol_of(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void spell_number(input logic signed [sre_pkg::NUM_W-1:0] value);
    logic [sre_pkg::NUM_W-1:0] magnitude;
    logic [sre_pkg::NUM_W-1:0] radix;
    int                        digits [$];
    char_item_t                item;
    if (!alphabet_usable()) return;
    radix = sre_pkg::NUM_W'(radix_setting);
    magnitude = value;
    if (value < 0) begin
      item.glyph = sre_pkg::CHAR_MINUS;
      item.final_char = 1'b0;
      pending_chars.push_back(item);
      magnitude = -magnitude;
    end
    do begin
      digits.push_front(int'(magnitude % radix));
      magnitude = magnitude / radix;
    end while (magnitude != 0);
    foreach (digits[i]) begin
      item.glyph = symbol_of(digits[i]);
      item.final_char = (i == digits.size() - 1);
      pending_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      radix_setting = '0;
      foreach (alpha_words[i]) alpha_words[i] = '0;
      pending_chars.delete();
      mismatches = 0;
      chars_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sre_pkg::CFG_SYM_COUNT: radix_setting = cfg_data[sre_pkg::RADIX_W-1:0];
          sre_pkg::CFG_ALPHA_0:   alpha_words[0] = cfg_data;
          sre_pkg::CFG_ALPHA_1:   alpha_words[1] = cfg_data;
          sre_pkg::CFG_ALPHA_2:   alpha_words[2] = cfg_data;
          sre_pkg::CFG_ALPHA_3:   alpha_words[3] = cfg_data;
          default: ;
        endcase
      end
      if (number_valid && number_ready) spell_number(number);
      if (char_valid && char_ready) begin
        if (pending_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected character %h (last %b) with nothing outstanding", character, last);
        end else begin
          head = pending_chars.pop_front();
          chars_checked++;
          if (character !== head.glyph || last !== head.final_char) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Character %0d: expected %h last %b, got %h last %b", chars_checked,
                       head.glyph, head.final_char, character, last);
          end
        end
      end
    end
    chars_pending = pending_chars.size();
  end

endmodule

[tb/tb_signed_radix_digit_emitter.sv]
`timescale 1ns / 100ps
// Testbench top for the signed radix digit emitter: loads alphabets, sends number requests,
// paces the character receiver and gives the verdict. Depends on sre_pkg, the block and
// sre_char_checker.
module tb_signed_radix_digit_emitter;

  localparam int RANDOM_NUMBERS = 410;
  localparam int SETTLE_CYCLES  = 120;
  localparam int HOLD_CYCLES    = 600;
  localparam int STALL_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef enum int {
    FLAW_NONE, FLAW_SHORT, FLAW_LONG, FLAW_PLUS, FLAW_MINUS, FLAW_LOW, FLAW_HIGH, FLAW_REPEAT
  } flaw_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [sre_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [sre_pkg::ALPHA_REG_W-1:0]     cfg_data = '0;
  logic                                number_valid = 1'b0;
  logic                                number_ready;
  logic signed [sre_pkg::NUM_W-1:0]    number = '0;
  logic                                char_valid;
  logic                                char_ready = 1'b0;
  logic [sre_pkg::CHAR_W-1:0]          character;
  logic                                last;

  int mismatches;
  int chars_pending;
  int chars_checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int numbers_sent = 0;
  int settings_used = 0;
  int bad_settings = 0;
  int stall_cycles = 0;
  int valid_numbers = 0;
  int goal;
  int count;
  logic [sre_pkg::CHAR_W-1:0] glyphs [sre_pkg::MAX_BASE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_radix_digit_emitter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .number_valid (number_valid),
    .number_ready (number_ready),
    .number       (number),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .character    (character),
    .last         (last)
  );

  sre_char_checker char_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .number_valid  (number_valid),
    .number_ready  (number_ready),
    .number        (number),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .character     (character),
    .last          (last),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  initial begin
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        char_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      char_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (number_valid && number_ready) ||
        (char_valid && char_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("No request accepted for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_register(input logic [sre_pkg::CFG_INDEX_W-1:0] index,
                                input logic [sre_pkg::ALPHA_REG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    number_valid <= 1'b0;
    wait (chars_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void pick_glyphs(input int used);
    bit          taken [256];
    logic [7:0]  c;
    foreach (glyphs[i]) glyphs[i] = 8'($urandom);
    for (int i = 0; i < used; i++) begin
      do c = 8'($urandom_range(sre_pkg::CHAR_SPACE, 127));
      while (taken[c] || c == sre_pkg::CHAR_PLUS || c == sre_pkg::CHAR_MINUS);
      taken[c] = 1'b1;
      glyphs[i] = c;
    end
  endfunction

  task automatic load_alphabet(input int used, input flaw_t flaw);
    logic [sre_pkg::ALPHA_REG_W-1:0] word;
    logic [sre_pkg::RADIX_W-1:0]     len;
    int                              pos;
    int                              other;
    settle();
    len = sre_pkg::RADIX_W'(used);
    pos = $urandom_range(0, used - 1);
    case (flaw)
      FLAW_SHORT:  len = sre_pkg::RADIX_W'($urandom_range(0, 1));
      FLAW_LONG:   len = sre_pkg::RADIX_W'($urandom_range(sre_pkg::MAX_BASE + 1, 63));
      FLAW_PLUS:   glyphs[pos] = sre_pkg::CHAR_PLUS;
      FLAW_MINUS:  glyphs[pos] = sre_pkg::CHAR_MINUS;
      FLAW_LOW:    glyphs[pos] = 8'($urandom_range(0, sre_pkg::CHAR_SPACE - 1));
      FLAW_HIGH:   glyphs[pos] = 8'($urandom_range(128, 255));
      FLAW_REPEAT: begin
        other = (pos + $urandom_range(1, used - 1)) % used;
        glyphs[other] = glyphs[pos];
      end
      default: ;
    endcase
    word = {$urandom, $urandom};
    word[sre_pkg::RADIX_W-1:0] = len;
    write_register(sre_pkg::CFG_SYM_COUNT, word);
    for (int r = 0; r < sre_pkg::ALPHA_REGS; r++) begin
      for (int b = 0; b < 8; b++) word[b * 8 +: 8] = glyphs[r * 8 + b];
      write_register(sre_pkg::CFG_INDEX_W'(int'(sre_pkg::CFG_ALPHA_0) + r), word);
    end
    if ($urandom_range(0, 2) == 0)
      write_register(sre_pkg::CFG_INDEX_W'(int'(sre_pkg::CFG_ALPHA_3) + $urandom_range(1, 3)),
                     {$urandom, $urandom});
    cfg_valid <= 1'b0;
    settings_used++;
    if (flaw != FLAW_NONE) bad_settings++;
  endtask

  task automatic send_number(input logic signed [sre_pkg::NUM_W-1:0] value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      number_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    number_valid <= 1'b1;
    number <= value;
    do @(posedge clk); while (!number_ready);
    @(negedge clk);
    numbers_sent++;
  endtask

  function automatic logic signed [sre_pkg::NUM_W-1:0] pick_number(input int radix);
    longint                           span;
    logic signed [sre_pkg::NUM_W-1:0] v;
    int                               k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, radix * radix);
      6:          v = -int'($urandom_range(1, radix * radix));
      7: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(sre_pkg::NUM_W - 1){1'b0}}};
          1:       v = {1'b0, {(sre_pkg::NUM_W - 1){1'b1}}};
          2:       v = '0;
          default: v = '1;
        endcase
      end
      8: begin
        span = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && span * radix <= 64'sh80000000) begin
          span = span * radix;
          k--;
        end
        v = sre_pkg::NUM_W'(span - $urandom_range(0, 1));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers still hold their reset values, so this request must produce nothing.
    send_number($urandom);

    pick_glyphs(0);
    for (int i = 0; i < 10; i++) glyphs[i] = 8'(8'h30 + i);
    load_alphabet(10, FLAW_NONE);
    send_number(0);
    send_number(1);
    send_number(-1);
    send_number(-10);
    send_number({1'b0, {(sre_pkg::NUM_W - 1){1'b1}}});
    send_number({1'b1, {(sre_pkg::NUM_W - 1){1'b0}}});
    send_number(1000000000);

    pick_glyphs(0);
    glyphs[0] = 8'h30;
    glyphs[1] = 8'h31;
    load_alphabet(2, FLAW_NONE);
    send_number({1'b1, {(sre_pkg::NUM_W - 1){1'b0}}});
    send_number({1'b0, {(sre_pkg::NUM_W - 1){1'b1}}});
    send_number(-1);
    send_number(0);

    pick_glyphs(0);
    glyphs[0] = sre_pkg::CHAR_SPACE;
    for (int i = 1; i < sre_pkg::MAX_BASE - 1; i++) glyphs[i] = 8'(8'h40 + i);
    glyphs[sre_pkg::MAX_BASE - 1] = 8'h7F;
    load_alphabet(sre_pkg::MAX_BASE, FLAW_NONE);
    send_number({1'b1, {(sre_pkg::NUM_W - 1){1'b0}}});
    send_number({1'b0, {(sre_pkg::NUM_W - 1){1'b1}}});
    send_number(31);
    send_number(32);

    for (int f = FLAW_SHORT; f <= FLAW_REPEAT; f++) begin
      pick_glyphs(8);
      load_alphabet(8, flaw_t'(f));
      send_number($urandom);
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = RANDOM_NUMBERS * (mode + 1) / 3;
      while (valid_numbers < goal) begin
        if ($urandom_range(0, 4) == 0) begin
          count = $urandom_range(2, sre_pkg::MAX_BASE);
          pick_glyphs(count);
          load_alphabet(count, flaw_t'($urandom_range(FLAW_SHORT, FLAW_REPEAT)));
          repeat (4) send_number(pick_number(count));
        end else begin
          case ($urandom_range(0, 3))
            0:       count = 2;
            1:       count = sre_pkg::MAX_BASE;
            default: count = $urandom_range(2, sre_pkg::MAX_BASE);
          endcase
          pick_glyphs(count);
          load_alphabet(count, FLAW_NONE);
          if (mode == 0 && holds_asked == 0) holds_asked++;
          repeat ($urandom_range(12, 30)) begin
            send_number(pick_number(count));
            valid_numbers++;
          end
        end
      end
    end

    number_valid <= 1'b0;
    wait (chars_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d numbers under %0d alphabet settings, %0d of them invalid.",
             numbers_sent, settings_used, bad_settings);
    $display("Checked %0d characters over radices 2 to %0d, including a long receiver hold-off.",
             chars_checked, sre_pkg::MAX_BASE);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
